// ===== src/msup_pkg.sv =====
// Shared types, codes and constants for the motor run supervisor.
package msup_pkg;

    localparam int OP_W        = 2;
    localparam int SPEED_W     = 16;
    localparam int FAULT_W     = 16;
    localparam int MODE_W      = 3;
    localparam int ERR_W       = 32;
    localparam int RPM_W       = 19;
    localparam int LIMIT_W     = 18;
    localparam int DEBOUNCE_W  = 8;
    localparam int TIMER_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 18;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 64;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STARTUP = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RUNNING = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOP    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ERROR   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERSPEED_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_TICKS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TICKS      = 2'd3;

    localparam logic [LIMIT_W-1:0]    RST_OVERSPEED_LIMIT = 18'd48000;
    localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE_TICKS  = 8'd10;
    localparam logic [TIMER_W-1:0]    RST_STARTUP_TICKS   = 16'd500;
    localparam logic [TIMER_W-1:0]    RST_STOP_TICKS      = 16'd100;

    localparam logic [ERR_W-1:0] OVERSPEED_BIT = 32'h8000_0000;

    typedef struct packed {
        logic [LIMIT_W-1:0]    overspeed_limit;
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [TIMER_W-1:0]    startup_ticks;
        logic [TIMER_W-1:0]    stop_ticks;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [SPEED_W-1:0] speed_reading;
        logic [FAULT_W-1:0]        faults_now;
        logic [FAULT_W-1:0]        faults_seen;
    } item_t;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic                    accepted;
        logic                    fault_latched;
        logic [ERR_W-1:0]        error_code;
        logic signed [RPM_W-1:0] speed_rpm;
        logic                    drive_start;
        logic                    drive_stop;
        logic                    fault_ack;
    } result_t;

endpackage

// ===== src/motor_run_supervisor.sv =====
// Motor run supervisor top level: stream input and result registers around the core.
// Data path: an accepted s_ item passes through the input register, then the result
// register; m_tvalid rises once the result register is loaded.
// Throughput: one item per cycle while m_tready does not stall the output; set by the
// combinational core update between the input register and the result register.
// Reset: aresetn synchronous, active low; mode idle, counters, fault state cleared.
module motor_run_supervisor
    import msup_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // speed_reading, faults_now, faults_seen
    input  logic [OP_W-1:0]       s_tuser,  // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // mode, accepted, fault_latched, error_code, speed_rpm, drive_start,
    // drive_stop, fault_ack, zero padding
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t out_res_reg;
    logic    out_valid_reg, out_valid_next;
    result_t core_res;
    logic    advance;
    logic    s_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign in_valid_next  = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    msup_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msup_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg.op            <= s_tuser;
            in_item_reg.speed_reading <= s_tdata[15:0];
            in_item_reg.faults_now    <= s_tdata[31:16];
            in_item_reg.faults_seen   <= s_tdata[47:32];
        end
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       out_res_reg.fault_ack,
                       out_res_reg.drive_stop,
                       out_res_reg.drive_start,
                       out_res_reg.speed_rpm,
                       out_res_reg.error_code,
                       out_res_reg.fault_latched,
                       out_res_reg.accepted,
                       out_res_reg.mode};

endmodule

// ===== src/msup_cfg.sv =====
// Configuration register bank for the motor run supervisor.
module msup_cfg
    import msup_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_OVERSPEED_LIMIT: cfg_next.overspeed_limit = cfg_data[LIMIT_W-1:0];
                CFG_DEBOUNCE_TICKS:  cfg_next.debounce_ticks  = cfg_data[DEBOUNCE_W-1:0];
                CFG_STARTUP_TICKS:   cfg_next.startup_ticks   = cfg_data[TIMER_W-1:0];
                CFG_STOP_TICKS:      cfg_next.stop_ticks      = cfg_data[TIMER_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.overspeed_limit <= RST_OVERSPEED_LIMIT;
            cfg_reg.debounce_ticks  <= RST_DEBOUNCE_TICKS;
            cfg_reg.startup_ticks   <= RST_STARTUP_TICKS;
            cfg_reg.stop_ticks      <= RST_STOP_TICKS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/msup_core.sv =====
// Mode sequencer, fault latch, overspeed debounce and mode timers.
module msup_core
    import msup_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    logic [MODE_W-1:0]     run_mode_reg, run_mode_next;
    logic [TIMER_W-1:0]    mode_timer_reg, mode_timer_next;
    logic [DEBOUNCE_W-1:0] os_count_reg, os_count_next;
    logic                  fault_flag_reg, fault_flag_next;
    logic [ERR_W-1:0]      error_word_reg, error_word_next;

    logic signed [RPM_W-1:0] rpm;
    logic                    fast;
    logic [DEBOUNCE_W-1:0]   cnt_inc;
    logic [TIMER_W-1:0]      tmr_inc;
    logic [ERR_W-1:0]        packed_faults;

    assign rpm = (RPM_W'(item.speed_reading) <<< 2) + (RPM_W'(item.speed_reading) <<< 1);
    assign fast = item.speed_reading[SPEED_W-1]
                  || (rpm[LIMIT_W-1:0] > cfg.overspeed_limit);
    assign cnt_inc = os_count_reg + DEBOUNCE_W'(1);
    assign tmr_inc = mode_timer_reg + TIMER_W'(1);
    assign packed_faults = {item.faults_now, item.faults_seen};

    always_comb begin
        run_mode_next   = run_mode_reg;
        mode_timer_next = mode_timer_reg;
        os_count_next   = os_count_reg;
        fault_flag_next = fault_flag_reg;
        error_word_next = error_word_reg;
        res             = '0;

        case (item.op)
            OP_TICK: begin
                res.accepted  = 1'b1;
                res.speed_rpm = rpm;
                if (run_mode_reg != MODE_IDLE && run_mode_reg != MODE_ERROR) begin
                    error_word_next = packed_faults;
                    if (packed_faults != '0) begin
                        fault_flag_next = 1'b1;
                        res.drive_stop  = 1'b1;
                        run_mode_next   = MODE_ERROR;
                        mode_timer_next = '0;
                    end
                end
                if (!fault_flag_next) begin
                    if (fast) begin
                        os_count_next = cnt_inc;
                        if (cnt_inc >= cfg.debounce_ticks) begin
                            os_count_next   = '0;
                            error_word_next = error_word_next | OVERSPEED_BIT;
                            fault_flag_next = 1'b1;
                            res.drive_stop  = 1'b1;
                            run_mode_next   = MODE_ERROR;
                            mode_timer_next = '0;
                        end
                    end else begin
                        os_count_next = '0;
                    end
                end
                // timers run only if no error was raised on this tick
                if (run_mode_next == MODE_STARTUP) begin
                    mode_timer_next = tmr_inc;
                    if (tmr_inc >= cfg.startup_ticks) begin
                        run_mode_next   = MODE_RUNNING;
                        mode_timer_next = '0;
                    end
                end else if (run_mode_next == MODE_STOP) begin
                    mode_timer_next = tmr_inc;
                    if (tmr_inc >= cfg.stop_ticks) begin
                        run_mode_next   = MODE_IDLE;
                        mode_timer_next = '0;
                    end
                end
            end
            OP_START: begin
                if (run_mode_reg == MODE_IDLE) begin
                    res.accepted    = 1'b1;
                    run_mode_next   = MODE_STARTUP;
                    mode_timer_next = '0;
                    fault_flag_next = 1'b0;
                    error_word_next = '0;
                    res.fault_ack   = 1'b1;
                    res.drive_start = 1'b1;
                end
            end
            OP_STOP: begin
                if (run_mode_reg == MODE_STARTUP || run_mode_reg == MODE_RUNNING) begin
                    res.accepted    = 1'b1;
                    run_mode_next   = MODE_STOP;
                    mode_timer_next = '0;
                    res.drive_stop  = 1'b1;
                end
            end
            OP_CLEAR: begin
                if (run_mode_reg == MODE_ERROR) begin
                    res.accepted    = 1'b1;
                    fault_flag_next = 1'b0;
                    error_word_next = '0;
                    res.fault_ack   = 1'b1;
                    run_mode_next   = MODE_IDLE;
                    mode_timer_next = '0;
                end
            end
            default: begin
                res.accepted = 1'b0;
            end
        endcase

        res.mode          = run_mode_next;
        res.fault_latched = fault_flag_next;
        res.error_code    = error_word_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_mode_reg   <= MODE_IDLE;
            mode_timer_reg <= '0;
            os_count_reg   <= '0;
            fault_flag_reg <= 1'b0;
            error_word_reg <= '0;
        end else if (fire) begin
            run_mode_reg   <= run_mode_next;
            mode_timer_reg <= mode_timer_next;
            os_count_reg   <= os_count_next;
            fault_flag_reg <= fault_flag_next;
            error_word_reg <= error_word_next;
        end
    end

    a_flag_iff_error: assert property (@(posedge aclk) disable iff (!aresetn)
        fault_flag_reg == (run_mode_reg == MODE_ERROR))
        else $error("fault flag out of step with error mode");

    a_timer_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_mode_reg != MODE_STARTUP && run_mode_reg != MODE_STOP) |-> mode_timer_reg == '0)
        else $error("mode timer running outside a timed mode");

    a_word_needs_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (error_word_reg != '0) |-> fault_flag_reg)
        else $error("error word held without latched fault");

    a_start_enters_startup: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.drive_start) |=> (run_mode_reg == MODE_STARTUP && !fault_flag_reg))
        else $error("start pulse without entering startup");

endmodule

// ===== tb/sv/motor_run_supervisor_tb.sv =====
// Self-checking testbench for motor_run_supervisor: directed and random stream traffic.
`timescale 1ns / 100ps

module motor_run_supervisor_tb;
    import msup_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 305;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    motor_run_supervisor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow configuration
    logic [LIMIT_W-1:0]    lim_rpm     = RST_OVERSPEED_LIMIT;
    logic [DEBOUNCE_W-1:0] fast_needed = RST_DEBOUNCE_TICKS;
    logic [TIMER_W-1:0]    spinup_len  = RST_STARTUP_TICKS;
    logic [TIMER_W-1:0]    coast_len   = RST_STOP_TICKS;

    // shadow supervisor state
    logic [MODE_W-1:0]     cur_mode    = MODE_IDLE;
    logic [TIMER_W-1:0]    dwell_count = '0;
    logic [DEBOUNCE_W-1:0] fast_run    = '0;
    logic                  trip_flag   = 1'b0;
    logic [ERR_W-1:0]      trip_word   = '0;

    item_t   pending_items[$];
    result_t expected_results[$];
    item_t   next_item;
    item_t   taken_item;
    result_t seen_result;
    result_t want_result;

    int n_queued = 0;
    int n_checked = 0;
    int n_errors = 0;
    int cycle_count = 0;
    int tx_idle_pct = 7;
    int rx_idle_pct = 74;
    int phase = 0;
    logic rx_hold = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void enter_mode(logic [MODE_W-1:0] m);
        cur_mode = m;
        dwell_count = '0;
    endfunction

    function automatic result_t supervise_item(item_t it);
        result_t r;
        logic signed [31:0] rpm;
        logic fast;
        r = '0;
        rpm = '0;
        case (it.op)
            OP_TICK: begin
                r.accepted = 1'b1;
                rpm = $signed(it.speed_reading) * 32'sd6;
                if (cur_mode != MODE_IDLE && cur_mode != MODE_ERROR) begin
                    trip_word = {it.faults_now, it.faults_seen};
                    if (trip_word != '0) begin
                        trip_flag = 1'b1;
                        r.drive_stop = 1'b1;
                        enter_mode(MODE_ERROR);
                    end
                end
                if (!trip_flag) begin
                    fast = rpm[31] || ($unsigned(rpm) > 32'(lim_rpm));
                    if (fast) begin
                        fast_run = fast_run + 1'b1;
                        if (fast_run >= fast_needed) begin
                            fast_run = '0;
                            trip_word = trip_word | OVERSPEED_BIT;
                            trip_flag = 1'b1;
                            r.drive_stop = 1'b1;
                            enter_mode(MODE_ERROR);
                        end
                    end else begin
                        fast_run = '0;
                    end
                end
                if (cur_mode == MODE_STARTUP) begin
                    dwell_count = dwell_count + 1'b1;
                    if (dwell_count >= spinup_len)
                        enter_mode(MODE_RUNNING);
                end else if (cur_mode == MODE_STOP) begin
                    dwell_count = dwell_count + 1'b1;
                    if (dwell_count >= coast_len)
                        enter_mode(MODE_IDLE);
                end
            end
            OP_START: begin
                if (cur_mode == MODE_IDLE) begin
                    r.accepted = 1'b1;
                    enter_mode(MODE_STARTUP);
                    trip_flag = 1'b0;
                    trip_word = '0;
                    r.fault_ack = 1'b1;
                    r.drive_start = 1'b1;
                end
            end
            OP_STOP: begin
                if (cur_mode == MODE_STARTUP || cur_mode == MODE_RUNNING) begin
                    r.accepted = 1'b1;
                    enter_mode(MODE_STOP);
                    r.drive_stop = 1'b1;
                end
            end
            default: begin
                if (cur_mode == MODE_ERROR) begin
                    r.accepted = 1'b1;
                    trip_flag = 1'b0;
                    trip_word = '0;
                    r.fault_ack = 1'b1;
                    enter_mode(MODE_IDLE);
                end
            end
        endcase
        r.mode = cur_mode;
        r.fault_latched = trip_flag;
        r.error_code = trip_word;
        r.speed_rpm = rpm[RPM_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (n_errors < 50)
            $display("result %0d: %s", n_checked, what);
        n_errors++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken_item.op = s_tuser;
                taken_item.speed_reading = s_tdata[15:0];
                taken_item.faults_now = s_tdata[31:16];
                taken_item.faults_seen = s_tdata[47:32];
                expected_results.push_back(supervise_item(taken_item));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_item.op;
                    s_tdata <= {next_item.faults_seen, next_item.faults_now,
                                next_item.speed_reading};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // result side
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want_result = expected_results.pop_front();
                seen_result.mode = m_tdata[2:0];
                seen_result.accepted = m_tdata[3];
                seen_result.fault_latched = m_tdata[4];
                seen_result.error_code = m_tdata[36:5];
                seen_result.speed_rpm = m_tdata[55:37];
                seen_result.drive_start = m_tdata[56];
                seen_result.drive_stop = m_tdata[57];
                seen_result.fault_ack = m_tdata[58];
                check_field("mode", 32'(seen_result.mode), 32'(want_result.mode));
                check_field("accepted", 32'(seen_result.accepted),
                            32'(want_result.accepted));
                check_field("fault_latched", 32'(seen_result.fault_latched),
                            32'(want_result.fault_latched));
                check_field("error_code", seen_result.error_code, want_result.error_code);
                check_field("speed_rpm", 32'(seen_result.speed_rpm),
                            32'(want_result.speed_rpm));
                check_field("drive_start", 32'(seen_result.drive_start),
                            32'(want_result.drive_start));
                check_field("drive_stop", 32'(seen_result.drive_stop),
                            32'(want_result.drive_stop));
                check_field("fault_ack", 32'(seen_result.fault_ack),
                            32'(want_result.fault_ack));
                n_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("motor_run_supervisor_tb NOT OK");
            $finish;
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial begin
        wait (phase == 5);
        repeat (20) @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_OVERSPEED_LIMIT: lim_rpm = LIMIT_W'(val);
            CFG_DEBOUNCE_TICKS:  fast_needed = DEBOUNCE_W'(val);
            CFG_STARTUP_TICKS:   spinup_len = TIMER_W'(val);
            default:             coast_len = TIMER_W'(val);
        endcase
    endtask

    task automatic set_regs(int unsigned lim, int unsigned deb, int unsigned su,
                            int unsigned st);
        write_reg(CFG_OVERSPEED_LIMIT, lim);
        write_reg(CFG_DEBOUNCE_TICKS, deb);
        write_reg(CFG_STARTUP_TICKS, su);
        write_reg(CFG_STOP_TICKS, st);
    endtask

    task automatic drain;
        while (n_checked != n_queued) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    task automatic add_item(logic [OP_W-1:0] op, logic [15:0] spd, logic [15:0] fnow,
                            logic [15:0] fseen);
        item_t it;
        it.op = op;
        it.speed_reading = spd;
        it.faults_now = fnow;
        it.faults_seen = fseen;
        pending_items.push_back(it);
        n_queued++;
    endtask

    task automatic add_cmd(logic [OP_W-1:0] op);
        add_item(op, rnd16(), rnd16(), rnd16());
    endtask

    function automatic int unsigned slow_ceiling();
        int unsigned c;
        c = lim_rpm / 6;
        return (c > 32767) ? 32767 : c;
    endfunction

    function automatic logic [15:0] slow_speed();
        return 16'($urandom_range(0, slow_ceiling()));
    endfunction

    function automatic logic [15:0] fast_speed();
        int unsigned c;
        c = slow_ceiling();
        if (c >= 32767 || $urandom_range(1) == 0)
            return 16'(-int'($urandom_range(1, 32768)));
        return 16'($urandom_range(c + 1, 32767));
    endfunction

    task automatic add_fault_tick();
        case ($urandom_range(3))
            0: add_item(OP_TICK, slow_speed(), rnd16() | 16'h1, 16'h0);
            1: add_item(OP_TICK, slow_speed(), 16'h0, rnd16() | 16'h1);
            2: add_item(OP_TICK, slow_speed(), 16'h1 << $urandom_range(15), 16'h0);
            default: add_item(OP_TICK, slow_speed(), rnd16(), rnd16() | 16'h8000);
        endcase
    endtask

    task automatic add_clean_tick();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3)
            add_fault_tick();
        else if (r < 8)
            add_item(OP_TICK, fast_speed(), 16'h0, 16'h0);
        else
            add_item(OP_TICK, slow_speed(), 16'h0, 16'h0);
    endtask

    function automatic int unsigned capped(int unsigned x);
        return (x > 40) ? 40 : x;
    endfunction

    task automatic add_episode();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(99);
        if (r < 45) begin
            // start, spin up, run, stop, coast down
            add_cmd(OP_START);
            n = $urandom_range(0, capped(spinup_len) + 3);
            repeat (n) add_clean_tick();
            if ($urandom_range(1))
                repeat ($urandom_range(0, 8)) add_clean_tick();
            if ($urandom_range(9) == 0)
                add_cmd(OP_START);
            add_cmd(OP_STOP);
            n = $urandom_range(0, capped(coast_len) + 3);
            repeat (n) add_clean_tick();
        end else if (r < 65) begin
            add_cmd(OP_START);
            repeat ($urandom_range(0, 4)) add_clean_tick();
            add_fault_tick();
            repeat ($urandom_range(0, 3))
                add_item(OP_TICK, rnd16(), rnd16(), rnd16());
            if ($urandom_range(9) < 7)
                add_cmd(OP_CLEAR);
        end else if (r < 80) begin
            n = $urandom_range(1, fast_needed + 2);
            repeat (n) begin
                if ($urandom_range(19) == 0)
                    add_item(OP_TICK, slow_speed(), 16'h0, 16'h0);
                else
                    add_item(OP_TICK, fast_speed(), 16'h0, 16'h0);
            end
            if ($urandom_range(1))
                add_cmd(OP_CLEAR);
        end else begin
            repeat ($urandom_range(1, 6))
                add_item(2'($urandom), rnd16(),
                         $urandom_range(1) ? rnd16() : 16'h0,
                         $urandom_range(1) ? rnd16() : 16'h0);
        end
    endtask

    task automatic add_random(int target);
        int start;
        start = n_queued;
        while (n_queued - start < target) add_episode();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        set_regs(30000, 3, 4, 3);
        add_item(OP_TICK, 16'h7fff, 16'hffff, 16'hffff);   // idle ignores faults, fast
        add_item(OP_TICK, 16'h8000, 16'h0000, 16'h0000);   // negative counts as fast
        add_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
        add_cmd(OP_STOP);
        add_cmd(OP_CLEAR);
        add_cmd(OP_START);
        add_cmd(OP_START);
        repeat (4) add_item(OP_TICK, 16'd1000, 16'h0000, 16'h0000);
        add_cmd(OP_STOP);
        repeat (3) add_item(OP_TICK, 16'd5000, 16'h0000, 16'h0000);
        add_cmd(OP_START);
        add_item(OP_TICK, 16'd5001, 16'hffff, 16'h0000);
        add_item(OP_TICK, 16'hffff, 16'h0001, 16'h0001);
        add_cmd(OP_START);
        add_cmd(OP_STOP);
        add_cmd(OP_CLEAR);
        repeat (3) add_item(OP_TICK, 16'hffff, 16'h0000, 16'h0000);  // trip from idle
        add_cmd(OP_CLEAR);
        add_cmd(OP_START);
        add_item(OP_TICK, 16'd0, 16'h0000, 16'h0001);
        add_cmd(OP_CLEAR);
        drain();

        set_regs(RST_OVERSPEED_LIMIT, RST_DEBOUNCE_TICKS, 6, 4);
        add_random(PHASE_ITEMS);
        phase = 1;
        drain();

        set_regs(0, 1, 1, 1);
        add_random(PHASE_ITEMS);
        phase = 2;
        drain();

        tx_idle_pct = 74;
        rx_idle_pct = 7;
        set_regs(262143, 255, 12, 9);
        add_random(PHASE_ITEMS);
        phase = 3;
        drain();

        set_regs(120000, 3, 65535, 65535);
        add_random(PHASE_ITEMS);
        phase = 4;
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_regs(30000, 2, 3, 2);
        add_random(PHASE_ITEMS);
        phase = 5;
        drain();

        set_regs(200000, 5, 20, 15);
        add_random(PHASE_ITEMS);
        phase = 6;
        drain();
        repeat (10) @(posedge aclk);

        if (expected_results.size() != 0)
            report_mismatch("expected results left over at end of run");
        if (n_errors == 0) begin
            $display("motor_run_supervisor_tb OK");
        end else begin
            $display("motor_run_supervisor_tb NOT OK");
        end
        $finish;
    end

endmodule
